@@ design/ett_pkg.sv @@
// ett_pkg: shared types and constants for the event timer table
// command codes, per-slot write and scan control structs, default sizes
// no dependencies
package ett_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int CMD_W         = 3;
   localparam int SLOT_W        = 4;
   localparam int FIELD_W       = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET     = 3'd0,
      CMD_RESET   = 3'd1,
      CMD_RESTART = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_ADJUST  = 3'd4,
      CMD_POLL    = 3'd5
   } cmd_type;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_EXPIRED = 1'b1
   } kind_type;

   typedef struct packed {
      logic              wr_en;
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
   } wr_ctl_type;

   typedef struct packed {
      logic advance;
      logic drain;
      logic poll;
   } scan_ctl_type;

endpackage

@@ design/ett_ifs.sv @@
// ett_ifs: valid/ready channel interfaces for the event timer table
// command channel and result channel, widths from ett_pkg
interface ett_req_if;
   logic                               valid;
   logic                               ready;
   logic [ett_pkg::CMD_W-1:0]          cmd;
   logic [ett_pkg::SLOT_W-1:0]         slot;
   logic [ett_pkg::FIELD_W-1:0]        interval;
   logic signed [ett_pkg::FIELD_W-1:0] time_shift;
   logic [ett_pkg::FIELD_W-1:0]        now;

   modport source (output valid, cmd, slot, interval, time_shift, now, input ready);
   modport sink   (input valid, cmd, slot, interval, time_shift, now, output ready);
endinterface

interface ett_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [ett_pkg::SLOT_W-1:0]  slot_out;
   logic [ett_pkg::FIELD_W-1:0] next_expiry;
   logic                        pending;
   logic                        last;

   modport source (output valid, kind, slot_out, next_expiry, pending, last, input ready);
   modport sink   (input valid, kind, slot_out, next_expiry, pending, last, output ready);
endinterface

@@ design/event_timer_table.sv @@
// channel   | dir | handshake        | item
// req_bus   | in  | valid/ready      | cmd, slot, interval, time_shift, now
// rsp_bus   | out | valid/ready      | kind, slot_out, next_expiry, pending, last
//
// one command at a time: the accept edge writes the addressed cell, then a scan
// token walks the row of SLOTS cells, one cell a cycle unless an expired result
// waits on a stalled output, and the summary loads once the token has left the
// last cell and the output is free; only then is the next command taken
// synchronous reset clears every slot, the token and the output valid
// depends on ett_pkg, ett_ifs and ett_cell
module event_timer_table #(
   parameter int SLOTS     = ett_pkg::SLOTS_DEF,
   parameter int TIME_BITS = ett_pkg::TIME_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   ett_req_if.sink  req_bus,
   ett_rsp_if.source rsp_bus
);

   logic [SLOTS:0]          tok;
   logic [SLOTS:0]          any_c;
   logic [TIME_BITS-1:0]    best_c [SLOTS+1];
   logic [SLOTS-1:0]        expire;

   logic                    busy_ff, busy_in;
   logic                    start_ff, start_in;
   logic                    poll_ff;
   logic [TIME_BITS-1:0]    now_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   ett_pkg::kind_type                 rsp_kind_ff, rsp_kind_in;
   logic [ett_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [ett_pkg::FIELD_W-1:0]       rsp_next_ff, rsp_next_in;
   logic                              rsp_pending_ff, rsp_pending_in;
   logic                              rsp_last_ff, rsp_last_in;

   ett_pkg::wr_ctl_type     wr;
   ett_pkg::scan_ctl_type   scan;
   logic [TIME_BITS-1:0]    req_now_t, req_ival_t, req_shift_t;
   logic [TIME_BITS-1:0]    expiry_t;
   logic [ett_pkg::SLOT_W-1:0] exp_slot;
   logic                    accept, out_free, emit_now, in_cells, sum_load;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   assign req_now_t   = TIME_BITS'(req_bus.now);
   assign req_ival_t  = TIME_BITS'(req_bus.interval);
   assign req_shift_t = TIME_BITS'(req_bus.time_shift);

   assign wr.wr_en = accept;
   assign wr.cmd   = ett_pkg::cmd_type'(req_bus.cmd);
   assign wr.slot  = req_bus.slot;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit_now = |expire;
   assign in_cells = |tok[SLOTS-1:0];
   assign sum_load = tok[SLOTS] && out_free;

   assign scan.advance = in_cells && (out_free || !emit_now);
   assign scan.drain   = sum_load;
   assign scan.poll    = poll_ff;

   assign tok[0]    = start_ff;
   assign any_c[0]  = 1'b0;
   assign best_c[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ett_cell #(
         .IDX       (i),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr          (wr),
         .wr_interval (req_ival_t),
         .wr_shift    (req_shift_t),
         .wr_now      (req_now_t),
         .scan        (scan),
         .scan_now    (now_ff),
         .token_prev  (tok[i]),
         .any_prev    (any_c[i]),
         .best_prev   (best_c[i]),
         .token_ff    (tok[i+1]),
         .any_ff      (any_c[i+1]),
         .best_ff     (best_c[i+1]),
         .expire      (expire[i])
      );
   end

   always_comb begin
      exp_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (expire[i]) begin
            exp_slot = exp_slot | ett_pkg::SLOT_W'(i);
         end
      end
   end

   assign expiry_t = now_ff + best_c[SLOTS];

   always_comb begin
      busy_in  = busy_ff;
      start_in = start_ff;
      if (accept) begin
         busy_in  = 1'b1;
         start_in = 1'b1;
      end else begin
         if (scan.advance) begin
            start_in = 1'b0;
         end
         if (sum_load) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_pending_in = rsp_pending_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit_now && scan.advance) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = ett_pkg::KIND_EXPIRED;
         rsp_slot_in    = exp_slot;
         rsp_next_in    = '0;
         rsp_pending_in = 1'b0;
         rsp_last_in    = 1'b0;
      end else if (sum_load) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = ett_pkg::KIND_SUMMARY;
         rsp_slot_in    = '0;
         rsp_next_in    = any_c[SLOTS] ? ett_pkg::FIELD_W'(expiry_t) : '0;
         rsp_pending_in = any_c[SLOTS];
         rsp_last_in    = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         poll_ff <= (ett_pkg::cmd_type'(req_bus.cmd) == ett_pkg::CMD_POLL);
         now_ff  <= req_now_t;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.slot_out    = rsp_slot_ff;
   assign rsp_bus.next_expiry = rsp_next_ff;
   assign rsp_bus.pending     = rsp_pending_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

@@ design/ett_cell.sv @@
// ett_cell: one timer slot of the chain, start time, interval and active mark
// checks expiry and folds its distance into the scan passed to its neighbor
// depends on ett_pkg
module ett_cell #(
   parameter int IDX       = 0,
   parameter int TIME_BITS = ett_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ett_pkg::wr_ctl_type    wr,
   input  logic [TIME_BITS-1:0]   wr_interval,
   input  logic [TIME_BITS-1:0]   wr_shift,
   input  logic [TIME_BITS-1:0]   wr_now,
   input  ett_pkg::scan_ctl_type  scan,
   input  logic [TIME_BITS-1:0]   scan_now,
   input  logic                   token_prev,
   input  logic                   any_prev,
   input  logic [TIME_BITS-1:0]   best_prev,
   output logic                   token_ff,
   output logic                   any_ff,
   output logic [TIME_BITS-1:0]   best_ff,
   output logic                   expire
);

   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic                 active_ff, active_in;
   logic                 token_in, any_in;
   logic [TIME_BITS-1:0] best_in;
   logic [TIME_BITS-1:0] remain;
   logic                 hit, expired, act_eff, take;

   assign hit     = wr.wr_en && (int'(wr.slot) == IDX);
   assign expired = (scan_now - start_ff) >= period_ff;
   assign expire  = token_prev && scan.poll && active_ff && expired;
   assign act_eff = active_ff && !expire;
   assign remain  = start_ff + period_ff - scan_now;
   assign take    = act_eff && (!any_prev || (remain < best_prev));

   always_comb begin
      start_in  = start_ff;
      period_in = period_ff;
      active_in = active_ff;
      if (hit) begin
         unique case (wr.cmd)
            ett_pkg::CMD_SET: begin
               start_in  = wr_now;
               period_in = wr_interval;
               active_in = 1'b1;
            end
            ett_pkg::CMD_RESET: begin
               start_in  = start_ff + period_ff;
               active_in = 1'b1;
            end
            ett_pkg::CMD_RESTART: begin
               start_in  = wr_now;
               active_in = 1'b1;
            end
            ett_pkg::CMD_STOP: begin
               active_in = 1'b0;
            end
            ett_pkg::CMD_ADJUST: begin
               start_in = start_ff + wr_shift;
            end
            default: begin
            end
         endcase
      end
      if (expire && scan.advance) begin
         active_in = 1'b0;
      end
   end

   always_comb begin
      if (scan.advance) begin
         token_in = token_prev;
         any_in   = any_prev || act_eff;
         best_in  = take ? remain : best_prev;
      end else begin
         token_in = token_ff && !scan.drain;
         any_in   = any_ff;
         best_in  = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         period_ff <= '0;
         active_ff <= 1'b0;
         token_ff  <= 1'b0;
         any_ff    <= 1'b0;
      end else begin
         start_ff  <= start_in;
         period_ff <= period_in;
         active_ff <= active_in;
         token_ff  <= token_in;
         any_ff    <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

endmodule

@@ verif/ett_checker.sv @@
// ett_checker: result checker for the event timer table testbench
// watches the command and result channels, keeps its own copy of the slot table,
// and compares every result item; depends on ett_pkg
module ett_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [ett_pkg::CMD_W-1:0]   req_cmd,
   input  logic [ett_pkg::SLOT_W-1:0]  req_slot,
   input  logic [ett_pkg::FIELD_W-1:0] req_interval,
   input  logic [ett_pkg::FIELD_W-1:0] req_time_shift,
   input  logic [ett_pkg::FIELD_W-1:0] req_now,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_kind,
   input  logic [ett_pkg::SLOT_W-1:0]  rsp_slot_out,
   input  logic [ett_pkg::FIELD_W-1:0] rsp_next_expiry,
   input  logic                        rsp_pending,
   input  logic                        rsp_last,
   output int                          error_count,
   output int                          results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                        kind;
      logic [ett_pkg::SLOT_W-1:0]  slot;
      logic [ett_pkg::FIELD_W-1:0] expiry;
      logic                        active;
      logic                        last;
   } timer_result_type;

   logic [ett_pkg::FIELD_W-1:0] slot_start  [ett_pkg::SLOTS_DEF];
   logic [ett_pkg::FIELD_W-1:0] slot_period [ett_pkg::SLOTS_DEF];
   bit                          slot_armed  [ett_pkg::SLOTS_DEF];
   timer_result_type            timer_results[$];
   int                          errors;

   task automatic clear_table();
      for (int i = 0; i < ett_pkg::SLOTS_DEF; i++) begin
         slot_start[i]  = '0;
         slot_period[i] = '0;
         slot_armed[i]  = 1'b0;
      end
   endtask

   task automatic predict_command(input logic [ett_pkg::CMD_W-1:0] cmd,
                                  input logic [ett_pkg::SLOT_W-1:0] slot,
                                  input logic [ett_pkg::FIELD_W-1:0] interval,
                                  input logic [ett_pkg::FIELD_W-1:0] shift,
                                  input logic [ett_pkg::FIELD_W-1:0] now);
      timer_result_type            res;
      logic [ett_pkg::FIELD_W-1:0] remain;
      logic [ett_pkg::FIELD_W-1:0] best;
      logic [ett_pkg::FIELD_W-1:0] elapsed;
      bit                          any;
      any  = 1'b0;
      best = '0;
      if (cmd == ett_pkg::CMD_POLL) begin
         for (int i = 0; i < ett_pkg::SLOTS_DEF; i++) begin
            elapsed = now - slot_start[i];
            if (slot_armed[i] && elapsed >= slot_period[i]) begin
               slot_armed[i] = 1'b0;
               res = '{ett_pkg::KIND_EXPIRED, ett_pkg::SLOT_W'(i), '0, 1'b0, 1'b0};
               timer_results.push_back(res);
            end
         end
      end else if (cmd <= ett_pkg::CMD_ADJUST && slot < ett_pkg::SLOTS_DEF) begin
         case (cmd)
            ett_pkg::CMD_SET: begin
               slot_start[slot]  = now;
               slot_period[slot] = interval;
               slot_armed[slot]  = 1'b1;
            end
            ett_pkg::CMD_RESET: begin
               slot_start[slot] = slot_start[slot] + slot_period[slot];
               slot_armed[slot] = 1'b1;
            end
            ett_pkg::CMD_RESTART: begin
               slot_start[slot] = now;
               slot_armed[slot] = 1'b1;
            end
            ett_pkg::CMD_STOP: begin
               slot_armed[slot] = 1'b0;
            end
            default: begin
               slot_start[slot] = slot_start[slot] + shift;
            end
         endcase
      end
      for (int i = 0; i < ett_pkg::SLOTS_DEF; i++) begin
         if (slot_armed[i]) begin
            remain = slot_start[i] + slot_period[i] - now;
            if (!any || remain < best) best = remain;
            any = 1'b1;
         end
      end
      remain = any ? now + best : '0;
      res    = '{ett_pkg::KIND_SUMMARY, '0, remain, any, 1'b1};
      timer_results.push_back(res);
   endtask

   initial begin
      errors      = 0;
      error_count = 0;
      results_due = 0;
      clear_table();
   end

   always @(posedge clock) begin
      timer_result_type want;
      timer_result_type got;
      if (reset) begin
         clear_table();
         timer_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_slot_out, rsp_next_expiry, rsp_pending, rsp_last};
            if (timer_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result item kind=%0d slot=%0d expiry=%08h",
                           $realtime, got.kind, got.slot, got.expiry);
            end else begin
               want = timer_results.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: result mismatch, expected kind=%0d slot=%0d expiry=%08h ",
                               "pending=%0d last=%0d, got kind=%0d slot=%0d expiry=%08h ",
                               "pending=%0d last=%0d"},
                              $realtime, want.kind, want.slot, want.expiry, want.active,
                              want.last, got.kind, got.slot, got.expiry, got.active, got.last);
               end
            end
         end
         if (req_valid && req_ready)
            predict_command(req_cmd, req_slot, req_interval, req_time_shift, req_now);
      end
      error_count <= errors;
      results_due <= timer_results.size();
   end

endmodule

@@ verif/tb_event_timer_table.sv @@
// tb_event_timer_table: testbench top for the event timer table
// drives directed and random timer commands with random stalls on both channels,
// gives the verdict; depends on ett_pkg, ett_ifs, event_timer_table and ett_checker
module tb_event_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ett_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [ett_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int                        CYCLE_LIMIT  = 500000;
   localparam int                        RANDOM_ITEMS = 280;
   localparam int                        QUIET_TAIL   = 40;

   logic clock;
   logic reset;
   bit   burst_on;
   bit   quiet;
   int   cycle_count;
   int   error_count;
   int   results_due;

   ett_req_if req_if ();
   ett_rsp_if rsp_if ();

   event_timer_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   ett_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_cmd         (req_if.cmd),
      .req_slot        (req_if.slot),
      .req_interval    (req_if.interval),
      .req_time_shift  (req_if.time_shift),
      .req_now         (req_if.now),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_kind        (rsp_if.kind),
      .rsp_slot_out    (rsp_if.slot_out),
      .rsp_next_expiry (rsp_if.next_expiry),
      .rsp_pending     (rsp_if.pending),
      .rsp_last        (rsp_if.last),
      .error_count     (error_count),
      .results_due     (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // alternate stretches with and without stalls
   initial begin
      burst_on <= 1'b1;
      forever begin
         repeat ($urandom_range(50, 300)) @(posedge clock);
         burst_on <= !burst_on;
      end
   end

   initial begin
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0)
            hold--;
         else if (burst_on && !quiet && $urandom_range(0, 2) == 0)
            hold = $urandom_range(1, 12);
         rsp_if.ready <= (hold == 0);
      end
   end

   task automatic issue(input logic [ett_pkg::CMD_W-1:0] cmd,
                        input logic [ett_pkg::SLOT_W-1:0] slot,
                        input logic [ett_pkg::FIELD_W-1:0] interval,
                        input logic [ett_pkg::FIELD_W-1:0] shift,
                        input logic [ett_pkg::FIELD_W-1:0] now);
      int gap;
      gap = 0;
      if (burst_on && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.cmd        <= cmd;
      req_if.slot       <= slot;
      req_if.interval   <= interval;
      req_if.time_shift <= shift;
      req_if.now        <= now;
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   initial begin
      logic [ett_pkg::FIELD_W-1:0] wall;
      logic [ett_pkg::FIELD_W-1:0] interval;
      logic [ett_pkg::FIELD_W-1:0] shift;
      logic [ett_pkg::FIELD_W-1:0] now;
      logic [ett_pkg::CMD_W-1:0]   cmd;
      logic [ett_pkg::SLOT_W-1:0]  slot;
      int                          pick;
      quiet             <= 1'b0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.cmd        <= '0;
      req_if.slot       <= '0;
      req_if.interval   <= '0;
      req_if.time_shift <= '0;
      req_if.now        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      issue(ett_pkg::CMD_POLL,    4'd0,  32'd0,         32'd0,         32'd0);
      issue(ett_pkg::CMD_SET,     4'd0,  32'd0,         32'd0,         32'd0);
      issue(ett_pkg::CMD_SET,     4'd15, 32'hFFFF_FFFF, 32'd0,         32'hFFFF_FFFF);
      issue(ett_pkg::CMD_SET,     4'd7,  32'd100,       32'd0,         32'd10);
      issue(ett_pkg::CMD_RESET,   4'd7,  32'd0,         32'd0,         32'd20);
      issue(ett_pkg::CMD_RESTART, 4'd7,  32'd0,         32'd0,         32'd50);
      issue(ett_pkg::CMD_ADJUST,  4'd7,  32'd0,         32'h8000_0000, 32'd60);
      issue(ett_pkg::CMD_ADJUST,  4'd7,  32'd0,         32'h7FFF_FFFF, 32'd60);
      issue(ett_pkg::CMD_ADJUST,  4'd7,  32'd0,         32'hFFFF_FFFF, 32'd60);
      issue(ett_pkg::CMD_ADJUST,  4'd3,  32'd0,         32'd5,         32'd65);
      issue(ett_pkg::CMD_RESET,   4'd3,  32'd0,         32'd0,         32'd70);
      issue(ett_pkg::CMD_STOP,    4'd15, 32'd0,         32'd0,         32'd70);
      issue(ett_pkg::CMD_STOP,    4'd9,  32'd0,         32'd0,         32'd70);
      issue(ett_pkg::CMD_POLL,    4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd200);
      issue(ett_pkg::CMD_POLL,    4'd15, 32'd0,         32'd0,         32'd200);
      issue(CMD_SPARE_LO,         4'd2,  32'd55,        32'd9,         32'd300);
      issue(CMD_SPARE_HI,         4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd300);
      issue(ett_pkg::CMD_SET,     4'd1,  32'd5,         32'd0,         32'hFFFF_FFFE);
      issue(ett_pkg::CMD_SET,     4'd2,  32'd10,        32'd0,         32'hFFFF_FFF0);
      issue(ett_pkg::CMD_SET,     4'd4,  32'd10,        32'd0,         32'hFFFF_FFF0);
      issue(ett_pkg::CMD_POLL,    4'd0,  32'd0,         32'd0,         32'd3);
      issue(ett_pkg::CMD_STOP,    4'd7,  32'd0,         32'd0,         32'd5);
      issue(ett_pkg::CMD_POLL,    4'd0,  32'd0,         32'd0,         32'hFFFF_FFFF);

      wall = 32'hFFFF_F800;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            cmd      = ett_pkg::CMD_W'($urandom_range(0, 7));
            slot     = ett_pkg::SLOT_W'($urandom);
            interval = $urandom;
            shift    = $urandom;
            now      = $urandom;
         end else begin
            wall     = wall + $urandom_range(0, 60);
            now      = wall;
            slot     = ett_pkg::SLOT_W'($urandom_range(0, 15));
            interval = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
            shift    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100) - 50;
            pick     = $urandom_range(0, 99);
            if (pick < 25)      cmd = ett_pkg::CMD_SET;
            else if (pick < 33) cmd = ett_pkg::CMD_RESET;
            else if (pick < 41) cmd = ett_pkg::CMD_RESTART;
            else if (pick < 49) cmd = ett_pkg::CMD_STOP;
            else if (pick < 57) cmd = ett_pkg::CMD_ADJUST;
            else if (pick < 96) cmd = ett_pkg::CMD_POLL;
            else                cmd = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
         end
         issue(cmd, slot, interval, shift, now);
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
